// ===== design/murmur2_hash_stream_assert.svh =====
// Assertion macros shared by the murmur2_hash_stream checker.
`ifndef MURMUR2_HASH_STREAM_ASSERT_SVH
`define MURMUR2_HASH_STREAM_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MH2S_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MH2S_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mh2s_pkg.sv =====
// Shared types, constants and command structs of the murmur2 hash stream.
`default_nettype none
package mh2s_pkg;

   localparam int DATA_W     = 64;
   localparam int HALF_W     = 32;
   localparam int VB_W       = 4;
   localparam int LEN_W      = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_SEED = 1'b1;

   localparam logic [HALF_W-1:0] SEED_RESET = 32'hc70f6907;
   localparam logic [DATA_W-1:0] MUL64      = 64'hc6a4a7935bd1e995;
   localparam logic [HALF_W-1:0] MUL_LO     = MUL64[HALF_W-1:0];
   localparam logic [HALF_W-1:0] MUL_HI     = MUL64[DATA_W-1:HALF_W];

   localparam int SHIFT_FIN64 = 47;
   localparam int SHIFT_MIX32 = 24;
   localparam int SHIFT_FIN_A = 13;
   localparam int SHIFT_FIN_B = 15;

   // multiplier operand A source
   typedef enum logic [2:0] {
      OPA_H_LO = 3'd0,
      OPA_H_HI = 3'd1,
      OPA_K_LO = 3'd2,
      OPA_K_HI = 3'd3,
      OPA_W_LO = 3'd4,
      OPA_W_HI = 3'd5,
      OPA_LEN  = 3'd6,
      OPA_ZERO = 3'd7
   } opa_sel_type;

   // partial product register action
   typedef enum logic [1:0] {
      P_HOLD  = 2'd0,
      P_LOAD  = 2'd1,
      P_ADDHI = 2'd2
   } p_op_type;

   // write-back action on the hash and key registers
   typedef enum logic [3:0] {
      WB_NONE        = 4'd0,
      WB_K_XS47      = 4'd1,
      WB_H_XOR_RES   = 4'd2,
      WB_H_RES       = 4'd3,
      WB_H_XS47      = 4'd4,
      WB_H_SEED_X    = 4'd5,
      WB_H_SHIFT47   = 4'd6,
      WB_H_XOR_W     = 4'd7,
      WB_K32_XS24    = 4'd8,
      WB_K32         = 4'd9,
      WB_H32_XORK    = 4'd10,
      WB_H32_SHIFT13 = 4'd11,
      WB_H32_XS15    = 4'd12
   } wb_op_type;

   typedef struct packed {
      opa_sel_type a_sel;
      logic        b_hi;
      p_op_type    p_op;
      wb_op_type   wb;
      logic        load_word;
      logic        load_len;
      logic        seed32;
      logic        load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic ge4;
      logic zero;
   } dp_status_type;

   localparam dp_cmd_type CMD_NOP = '{
      a_sel: OPA_ZERO, b_hi: 1'b0, p_op: P_HOLD, wb: WB_NONE,
      load_word: 1'b0, load_len: 1'b0, seed32: 1'b0, load_rsp: 1'b0
   };

endpackage
`default_nettype wire

// ===== design/mh2s_if.sv =====
// Request and response channel interfaces of the murmur2 hash stream.
`default_nettype none
interface mh2s_req_if;
   import mh2s_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_word;
   logic [VB_W-1:0]   valid_bytes;
   logic [LEN_W-1:0]  total_length;
   logic              first;
   logic              last;

   modport source (
      output valid, data_word, valid_bytes, total_length, first, last,
      input  ready
   );
   modport sink (
      input  valid, data_word, valid_bytes, total_length, first, last,
      output ready
   );
endinterface

interface mh2s_rsp_if;
   import mh2s_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink (input valid, hash_value, output ready);
endinterface
`default_nettype wire

// ===== design/murmur2_hash_stream.sv =====
// Top level of the murmur2 hash stream (MurmurHash64A and MurmurHash2A forms).
// Per word, one 32x32 multiplier does all products, in both the 64-bit and the 32-bit form.
// In the 64-bit form a first word first mixes the length into the seed.
// A finished hash sits in an output register, so the next request is taken meanwhile.
// Synchronous active-high reset: idle, no message open, wide_mode 1, seed 0xc70f6907.
`default_nettype none
module murmur2_hash_stream (
   input  logic                              clock,
   input  logic                              reset,
   mh2s_req_if.sink                          req_chan,
   mh2s_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_en,
   input  logic [mh2s_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mh2s_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import mh2s_pkg::*;

   // Configuration registers. The user must make writes only while the block is idle;
   // the block itself does not enforce this. The seed is read straight from here when a first request is mixed.
   logic              wide_mode_ff, wide_mode_in;
   logic [HALF_W-1:0] hash_seed_ff, hash_seed_in;

   always_comb begin
      wide_mode_in = wide_mode_ff;
      hash_seed_in = hash_seed_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_WIDE_MODE: wide_mode_in = csr_write_data[0];
            CSR_HASH_SEED: hash_seed_in = csr_write_data[HALF_W-1:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_mode_ff <= 1'b1;
         hash_seed_ff <= SEED_RESET;
      end else begin
         wide_mode_ff <= wide_mode_in;
         hash_seed_ff <= hash_seed_in;
      end
   end

   // Controller <-> datapath: one command word per cycle out, the
   // byte-count class of the presented request back.
   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller owns the handshakes. Ready is high only in its idle
   // state; a request outside an open message without first is taken
   // and dropped. The result valid bit belongs to the output register,
   // which is refilled once it is empty or being taken.
   mh2s_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_first (req_chan.first),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .wide_mode (wide_mode_ff),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the masked word, the stored length, the running
   // hash, a key register, the partial-product register and the result.
   // 64-bit products are built as lo*lo, then lo*hi and hi*lo into the
   // upper half, one partial product a cycle.
   mh2s_datapath u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .data_word    (req_chan.data_word),
      .valid_bytes  (req_chan.valid_bytes),
      .total_length (req_chan.total_length),
      .req_last     (req_chan.last),
      .hash_seed    (hash_seed_ff),
      .status       (status),
      .hash_value   (rsp_chan.hash_value)
   );

endmodule
`default_nettype wire

// ===== design/mh2s_datapath.sv =====
// Hash datapath: word and length registers, shared 32x32 multiplier, hash state.
`default_nettype none
module mh2s_datapath (
   input  logic                           clock,
   input  mh2s_pkg::dp_cmd_type           cmd,
   input  logic [mh2s_pkg::DATA_W-1:0]    data_word,
   input  logic [mh2s_pkg::VB_W-1:0]      valid_bytes,
   input  logic [mh2s_pkg::LEN_W-1:0]     total_length,
   input  logic                           req_last,
   input  logic [mh2s_pkg::HALF_W-1:0]    hash_seed,
   output mh2s_pkg::dp_status_type        status,
   output logic [mh2s_pkg::DATA_W-1:0]    hash_value
);
   import mh2s_pkg::*;

   logic [DATA_W-1:0] h_ff, h_in;
   logic [DATA_W-1:0] k_ff, k_in;
   logic [DATA_W-1:0] w_ff, w_in;
   logic [DATA_W-1:0] p_ff, p_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [DATA_W-1:0] rsp_ff, rsp_in;

   logic [VB_W-1:0]   vb_eff;
   logic [DATA_W-1:0] byte_mask;
   logic [HALF_W-1:0] mul_a;
   logic [HALF_W-1:0] mul_b;
   logic [DATA_W-1:0] prod;
   logic [DATA_W-1:0] res64;
   logic [HALF_W-1:0] r32;
   logic [DATA_W-1:0] seed64;

   // short words only count on the last word; above eight means eight
   assign vb_eff = (!req_last || valid_bytes[VB_W-1]) ? VB_W'(8) : valid_bytes;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         byte_mask[i*8 +: 8] = (VB_W'(i) < vb_eff) ? 8'hff : 8'h00;
      end
   end

   assign status.full = vb_eff[VB_W-1];
   assign status.ge4  = vb_eff[VB_W-1] | vb_eff[VB_W-2];
   assign status.zero = (vb_eff == '0);

   always_comb begin
      case (cmd.a_sel)
         OPA_H_LO: mul_a = h_ff[HALF_W-1:0];
         OPA_H_HI: mul_a = h_ff[DATA_W-1:HALF_W];
         OPA_K_LO: mul_a = k_ff[HALF_W-1:0];
         OPA_K_HI: mul_a = k_ff[DATA_W-1:HALF_W];
         OPA_W_LO: mul_a = w_ff[HALF_W-1:0];
         OPA_W_HI: mul_a = w_ff[DATA_W-1:HALF_W];
         OPA_LEN:  mul_a = len_ff;
         default:  mul_a = '0;
      endcase
   end

   assign mul_b  = cmd.b_hi ? MUL_HI : MUL_LO;
   assign prod   = DATA_W'(mul_a) * DATA_W'(mul_b);
   // 64-bit product truncated: cross terms land in the upper half
   assign res64  = p_ff + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
   assign r32    = prod[HALF_W-1:0];
   assign seed64 = {{HALF_W{1'b0}}, hash_seed};

   always_comb begin
      h_in   = h_ff;
      k_in   = k_ff;
      w_in   = w_ff;
      p_in   = p_ff;
      len_in = len_ff;
      rsp_in = rsp_ff;

      if (cmd.load_word) begin
         w_in = data_word & byte_mask;
      end
      if (cmd.load_len) begin
         len_in = total_length;
      end
      if (cmd.seed32) begin
         h_in = seed64;
      end

      case (cmd.p_op)
         P_LOAD:  p_in = prod;
         P_ADDHI: p_in = res64;
         default: p_in = p_ff;
      endcase

      case (cmd.wb)
         WB_K_XS47:      k_in = res64 ^ (res64 >> SHIFT_FIN64);
         WB_H_XOR_RES:   h_in = h_ff ^ res64;
         WB_H_RES:       h_in = res64;
         WB_H_XS47:      h_in = res64 ^ (res64 >> SHIFT_FIN64);
         WB_H_SEED_X:    h_in = seed64 ^ res64;
         WB_H_SHIFT47:   h_in = h_ff ^ (h_ff >> SHIFT_FIN64);
         WB_H_XOR_W:     h_in = h_ff ^ w_ff;
         WB_K32_XS24:    k_in = {{HALF_W{1'b0}}, r32 ^ (r32 >> SHIFT_MIX32)};
         WB_K32:         k_in = {{HALF_W{1'b0}}, r32};
         WB_H32_XORK:    h_in = {{HALF_W{1'b0}}, r32 ^ k_ff[HALF_W-1:0]};
         WB_H32_SHIFT13: h_in = {{HALF_W{1'b0}},
                                 h_ff[HALF_W-1:0] ^ (h_ff[HALF_W-1:0] >> SHIFT_FIN_A)};
         WB_H32_XS15:    h_in = {{HALF_W{1'b0}}, r32 ^ (r32 >> SHIFT_FIN_B)};
         default:        ;
      endcase

      if (cmd.load_rsp) begin
         rsp_in = h_ff;
      end
   end

   always_ff @(posedge clock) begin
      h_ff   <= h_in;
      k_ff   <= k_in;
      w_ff   <= w_in;
      p_ff   <= p_in;
      len_ff <= len_in;
      rsp_ff <= rsp_in;
   end

   assign hash_value = rsp_ff;

endmodule
`default_nettype wire

// ===== design/mh2s_ctrl.sv =====
// Sequencer for the murmur2 hash stream: steps the datapath through each word.
`default_nettype none
module mh2s_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_first,
   input  logic                     req_last,
   output logic                     req_ready,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   input  logic                     wide_mode,
   input  mh2s_pkg::dp_status_type  status,
   output mh2s_pkg::dp_cmd_type     cmd
);
   import mh2s_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SEED  = 8'b0000_0010,
      ST_WBLK  = 8'b0000_0100,
      ST_WTAIL = 8'b0000_1000,
      ST_WFIN  = 8'b0001_0000,
      ST_NMIX  = 8'b0010_0000,
      ST_NFIN  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   typedef enum logic [1:0] {
      SRC_LO   = 2'd0,
      SRC_HI   = 2'd1,
      SRC_ZERO = 2'd2,
      SRC_LEN  = 2'd3
   } mix_src_type;

   state_type   state_ff, state_in;
   logic [1:0]  sub_ff, sub_in;
   logic [1:0]  pass_ff, pass_in;
   mix_src_type src_ff, src_in;
   logic        wide_ff, wide_in;
   logic        last_ff, last_in;
   logic        full_ff, full_in;
   logic        ge4_ff, ge4_in;
   logic        zero_ff, zero_in;
   logic        msg_ff, msg_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // one third of a 64x64 truncated multiply per cycle
   function automatic dp_cmd_type mul64_cmd(input opa_sel_type lo_sel,
                                            input opa_sel_type hi_sel,
                                            input logic [1:0]  sub,
                                            input wb_op_type   wb);
      dp_cmd_type c;
      c = CMD_NOP;
      case (sub)
         2'd0: begin
            c.a_sel = lo_sel;
            c.p_op  = P_LOAD;
         end
         2'd1: begin
            c.a_sel = lo_sel;
            c.b_hi  = 1'b1;
            c.p_op  = P_ADDHI;
         end
         default: begin
            c.a_sel = hi_sel;
            c.wb    = wb;
         end
      endcase
      return c;
   endfunction

   function automatic state_type work_state(input logic wide, input logic full,
                                            input logic zero);
      state_type s;
      if (!wide) begin
         s = ST_NMIX;
      end else if (full) begin
         s = ST_WBLK;
      end else if (zero) begin
         s = ST_WFIN;
      end else begin
         s = ST_WTAIL;
      end
      return s;
   endfunction

   function automatic opa_sel_type src_opa(input mix_src_type s);
      opa_sel_type o;
      case (s)
         SRC_LO:   o = OPA_W_LO;
         SRC_HI:   o = OPA_W_HI;
         SRC_ZERO: o = OPA_ZERO;
         default:  o = OPA_LEN;
      endcase
      return o;
   endfunction

   always_comb begin
      state_in     = state_ff;
      sub_in       = sub_ff + 2'd1;
      pass_in      = pass_ff;
      src_in       = src_ff;
      wide_in      = wide_ff;
      last_in      = last_ff;
      full_in      = full_ff;
      ge4_in       = ge4_ff;
      zero_in      = zero_ff;
      msg_in       = msg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = CMD_NOP;

      case (state_ff)
         ST_IDLE: begin
            sub_in  = 2'd0;
            pass_in = 2'd0;
            src_in  = SRC_LO;
            // words outside a message are taken and dropped
            if (req_valid && (req_first || msg_ff)) begin
               cmd.load_word = 1'b1;
               wide_in       = wide_mode;
               last_in       = req_last;
               full_in       = status.full;
               ge4_in        = status.ge4;
               zero_in       = status.zero;
               msg_in        = 1'b1;
               if (req_first) begin
                  cmd.load_len = 1'b1;
                  if (wide_mode) begin
                     state_in = ST_SEED;
                  end else begin
                     cmd.seed32 = 1'b1;
                     state_in   = ST_NMIX;
                  end
               end else begin
                  state_in = work_state(wide_mode, status.full, status.zero);
               end
            end
         end

         ST_SEED: begin
            cmd.a_sel = OPA_LEN;
            if (sub_ff == 2'd0) begin
               cmd.p_op = P_LOAD;
            end else begin
               cmd.b_hi = 1'b1;
               cmd.wb   = WB_H_SEED_X;
               sub_in   = 2'd0;
               state_in = work_state(wide_ff, full_ff, zero_ff);
            end
         end

         ST_WBLK: begin
            case (pass_ff)
               2'd0:    cmd = mul64_cmd(OPA_W_LO, OPA_W_HI, sub_ff, WB_K_XS47);
               2'd1:    cmd = mul64_cmd(OPA_K_LO, OPA_K_HI, sub_ff, WB_H_XOR_RES);
               default: cmd = mul64_cmd(OPA_H_LO, OPA_H_HI, sub_ff, WB_H_RES);
            endcase
            if (sub_ff == 2'd2) begin
               sub_in  = 2'd0;
               pass_in = pass_ff + 2'd1;
               if (pass_ff == 2'd2) begin
                  pass_in  = 2'd0;
                  state_in = last_ff ? ST_WFIN : ST_IDLE;
               end
            end
         end

         ST_WTAIL: begin
            if (pass_ff == 2'd0) begin
               cmd.wb  = WB_H_XOR_W;
               sub_in  = 2'd0;
               pass_in = 2'd1;
            end else begin
               cmd = mul64_cmd(OPA_H_LO, OPA_H_HI, sub_ff, WB_H_RES);
               if (sub_ff == 2'd2) begin
                  sub_in   = 2'd0;
                  pass_in  = 2'd0;
                  state_in = ST_WFIN;
               end
            end
         end

         ST_WFIN: begin
            if (pass_ff == 2'd0) begin
               cmd.wb  = WB_H_SHIFT47;
               sub_in  = 2'd0;
               pass_in = 2'd1;
            end else begin
               cmd = mul64_cmd(OPA_H_LO, OPA_H_HI, sub_ff, WB_H_XS47);
               if (sub_ff == 2'd2) begin
                  sub_in   = 2'd0;
                  pass_in  = 2'd0;
                  state_in = ST_DONE;
               end
            end
         end

         ST_NMIX: begin
            case (sub_ff)
               2'd0: begin
                  cmd.a_sel = src_opa(src_ff);
                  cmd.wb    = WB_K32_XS24;
               end
               2'd1: begin
                  cmd.a_sel = OPA_K_LO;
                  cmd.wb    = WB_K32;
               end
               default: begin
                  cmd.a_sel = OPA_H_LO;
                  cmd.wb    = WB_H32_XORK;
                  sub_in    = 2'd0;
                  // block order: low half, high half, tail, length
                  case (src_ff)
                     SRC_LO: begin
                        src_in = ge4_ff ? SRC_HI : SRC_LEN;
                     end
                     SRC_HI: begin
                        if (!last_ff) begin
                           state_in = ST_IDLE;
                        end else begin
                           src_in = full_ff ? SRC_ZERO : SRC_LEN;
                        end
                     end
                     SRC_ZERO: begin
                        src_in = SRC_LEN;
                     end
                     default: begin
                        state_in = ST_NFIN;
                     end
                  endcase
               end
            endcase
         end

         ST_NFIN: begin
            if (sub_ff == 2'd0) begin
               cmd.wb = WB_H32_SHIFT13;
            end else begin
               cmd.a_sel = OPA_H_LO;
               cmd.wb    = WB_H32_XS15;
               sub_in    = 2'd0;
               state_in  = ST_DONE;
            end
         end

         ST_DONE: begin
            sub_in = 2'd0;
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               msg_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            sub_in   = 2'd0;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sub_ff       <= 2'd0;
         pass_ff      <= 2'd0;
         src_ff       <= SRC_LO;
         wide_ff      <= 1'b1;
         last_ff      <= 1'b0;
         full_ff      <= 1'b0;
         ge4_ff       <= 1'b0;
         zero_ff      <= 1'b0;
         msg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sub_ff       <= sub_in;
         pass_ff      <= pass_in;
         src_ff       <= src_in;
         wide_ff      <= wide_in;
         last_ff      <= last_in;
         full_ff      <= full_in;
         ge4_ff       <= ge4_in;
         zero_ff      <= zero_in;
         msg_ff       <= msg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== design/mh2s_checker.sv =====
// Port-level assertions for murmur2_hash_stream and the bind that attaches them.
`default_nettype none
`include "murmur2_hash_stream_assert.svh"

module mh2s_checker (
   input logic        clock,
   input logic        reset,
   mh2s_req_if.sink   req_chan,
   mh2s_rsp_if.source rsp_chan
);
   logic req_fire;

   assign req_fire = req_chan.valid && req_chan.ready;

   `MH2S_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid, "result dropped while stalled")
   `MH2S_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_chan.valid && !rsp_chan.ready, $stable(rsp_chan.hash_value), "stalled hash changed")
   `MH2S_ASSERT_NEXT(a_first_busy, clock, reset, req_fire && req_chan.first, !req_chan.ready, "first request did not start work")
   `MH2S_ASSERT_SAME(a_no_instant, clock, reset, $rose(rsp_chan.valid), !$past(req_fire), "result right after a request")

endmodule

bind murmur2_hash_stream mh2s_checker u_mh2s_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
`default_nettype wire

// ===== verif/tb_murmur2_hash_stream.sv =====
// Self-checking testbench for murmur2_hash_stream: directed table, then random messages.
module tb_murmur2_hash_stream;
   import mh2s_pkg::*;

   // Run limits. SETTLE covers the longest word-to-idle time of the engine.
   localparam int WORD_TARGET = 2000;
   localparam int SETTLE      = 40;
   localparam int CYCLE_LIMIT = 600000;
   localparam int GAP_MAX     = 11;
   localparam int SHOW_MAX    = 10;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [VB_W-1:0]   vb;
      logic [LEN_W-1:0]  len;
      logic              first;
      logic              last;
   } word_req_type;

   typedef enum logic [1:0] {
      WORD_IGNORED,
      WORD_TAKEN,
      HASH_DONE
   } word_outcome_type;

   typedef enum logic {
      ROW_REQUEST,
      ROW_CSR
   } row_kind_type;

   // One line of the directed table: a request, or a register write.
   // A pinned row carries a hash that is known without working it out.
   typedef struct packed {
      row_kind_type           kind;
      word_req_type           req;
      logic [CSR_IDX_W-1:0]   csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
      logic                   pinned;
      logic [DATA_W-1:0]      pinned_hash;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   mh2s_req_if req_bus ();
   mh2s_rsp_if rsp_bus ();

   murmur2_hash_stream dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   // Engine state as the predictor sees it.
   logic              model_wide;
   logic [HALF_W-1:0] model_seed;
   logic [DATA_W-1:0] model_acc;
   logic [LEN_W-1:0]  model_len;
   logic              model_open;

   logic [DATA_W-1:0] hashes_due [$];
   plan_row_type      plan [$];
   int                words_taken = 0;
   int                error_count = 0;
   int                cycle_count = 0;
   bit                no_gaps     = 1'b0;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] p;
      p = a * b;
      return p;
   endfunction

   // One 4-byte block of the 32-bit form
   function automatic logic [31:0] mix_block32(input logic [31:0] h, input logic [31:0] k);
      k = mul32(k, MUL_LO);
      k = k ^ (k >> SHIFT_MIX32);
      k = mul32(k, MUL_LO);
      h = mul32(h, MUL_LO);
      return h ^ k;
   endfunction

   // One 8-byte block of the 64-bit form
   function automatic logic [63:0] mix_block64(input logic [63:0] h, input logic [63:0] k);
      k = k * MUL64;
      k = k ^ (k >> SHIFT_FIN64);
      k = k * MUL64;
      h = h ^ k;
      h = h * MUL64;
      return h;
   endfunction

   // Folds one accepted word into the model; hands back the hash on a last word.
   function automatic word_outcome_type absorb_word(input word_req_type r,
                                                    output logic [DATA_W-1:0] digest);
      logic [63:0] w;
      logic [63:0] h;
      logic [3:0]  nb;
      logic [31:0] h32;
      logic [31:0] tail;
      digest = '0;
      if (r.first) begin
         model_len  = r.len;
         model_acc  = model_wide ? ({32'd0, model_seed} ^ ({32'd0, r.len} * MUL64))
                                 : {32'd0, model_seed};
         model_open = 1'b1;
      end else if (!model_open) begin
         // stray word outside a message
         return WORD_IGNORED;
      end

      // only a last word may be short; counts above eight saturate
      nb = (r.vb > 4'd8 || !r.last) ? 4'd8 : r.vb;
      w  = (nb == 4'd8) ? r.data : (r.data & ((64'd1 << (8 * nb)) - 64'd1));
      h  = model_acc;

      if (model_wide) begin
         if (nb == 4'd8) begin
            h = mix_block64(h, w);
         end else if (nb != 4'd0) begin
            h = (h ^ w) * MUL64;
         end
         if (r.last) begin
            h = h ^ (h >> SHIFT_FIN64);
            h = h * MUL64;
            h = h ^ (h >> SHIFT_FIN64);
         end
      end else begin
         // 32-bit form runs on the low half of the accumulator
         h32  = h[31:0];
         tail = w[31:0];
         if (nb >= 4'd4) begin
            h32 = mix_block32(h32, w[31:0]);
            // a full word leaves an empty tail block
            if (nb == 4'd8) begin
               h32  = mix_block32(h32, w[63:32]);
               tail = '0;
            end else begin
               tail = w[63:32];
            end
         end
         if (r.last) begin
            h32 = mix_block32(h32, tail);
            h32 = mix_block32(h32, model_len);
            h32 = h32 ^ (h32 >> SHIFT_FIN_A);
            h32 = mul32(h32, MUL_LO);
            h32 = h32 ^ (h32 >> SHIFT_FIN_B);
         end
         h = {32'd0, h32};
      end

      model_acc = h;
      if (!r.last) return WORD_TAKEN;
      model_open = 1'b0;
      digest     = h;
      return HASH_DONE;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic word_req_type make_req(input logic [63:0] d, input logic [3:0] vb,
                                             input logic [31:0] len, input logic f,
                                             input logic l);
      word_req_type r;
      r.data  = d;
      r.vb    = vb;
      r.len   = len;
      r.first = f;
      r.last  = l;
      return r;
   endfunction

   function automatic plan_row_type req_row(input word_req_type r, input logic pin,
                                            input logic [63:0] hash);
      plan_row_type p;
      p             = '0;
      p.kind        = ROW_REQUEST;
      p.req         = r;
      p.pinned      = pin;
      p.pinned_hash = hash;
      return p;
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      plan_row_type p;
      p         = '0;
      p.kind    = ROW_CSR;
      p.csr_idx = idx;
      p.csr_val = val;
      return p;
   endfunction

   // Appends one row to the directed table.
   function automatic void add_row(input plan_row_type r);
      plan.insert(plan.size(), r);
   endfunction

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   // Mostly random words, now and then all zeros or all ones.
   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= SHOW_MAX) $display("%s", msg);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   // Valid only drops when a gap is drawn, so back-to-back requests keep it high.
   task automatic send_request(input word_req_type r, input logic pin = 1'b0,
                               input logic [63:0] pin_hash = '0);
      int               gap;
      word_outcome_type outcome;
      logic [63:0]      digest;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.data_word    = r.data;
      req_bus.valid_bytes  = r.vb;
      req_bus.total_length = r.len;
      req_bus.first        = r.first;
      req_bus.last         = r.last;
      req_bus.valid        = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      outcome = absorb_word(r, digest);
      if (outcome != WORD_IGNORED) words_taken++;
      if (outcome == HASH_DONE) hashes_due.insert(hashes_due.size(), pin ? pin_hash : digest);
      @(negedge clock);
   endtask

   // Register writes only land on a quiet engine: nothing due and the
   // last accepted word given time to finish.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      req_bus.valid = 1'b0;
      while (hashes_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_write_en   = 1'b1;
      csr_index      = idx;
      csr_write_data = val;
      @(negedge clock);
      csr_write_en = 1'b0;
      if (idx == CSR_WIDE_MODE) model_wide = val[0];
      else if (idx == CSR_HASH_SEED) model_seed = val;
   endtask

   // Well-formed message; length normally matches the bytes sent.
   task automatic send_message(input int words, input bit junk_len);
      logic [3:0]  tail_vb;
      logic [3:0]  body_vb;
      logic [31:0] len;
      tail_vb = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
      len     = junk_len ? $urandom : (words - 1) * 8 + ((tail_vb > 4'd8) ? 8 : tail_vb);
      for (int i = 0; i < words; i++) begin
         // short counts on inner words get overridden to a full word
         body_vb = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
         send_request(make_req(rand_word(), (i == words - 1) ? tail_vb : body_vb, len,
                               i == 0, i == words - 1));
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: random stalls, every hash compared in order
   // ------------------------------------------------------------------
   initial begin
      int          stall;
      logic [63:0] want;
      rsp_bus.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if (hashes_due.size() == 0) begin
            flag_error($sformatf("unexpected hash %016h", rsp_bus.hash_value));
         end else begin
            want = hashes_due.pop_front();
            if (rsp_bus.hash_value !== want)
               flag_error($sformatf("hash_value mismatch: expected %016h, got %016h",
                                    want, rsp_bus.hash_value));
         end
         @(negedge clock);
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int          phase;
      int          phase_base;
      int          pick;
      int          nwords;
      logic        wide;
      logic [31:0] seed;

      req_bus.valid        = 1'b0;
      req_bus.data_word    = '0;
      req_bus.valid_bytes  = '0;
      req_bus.total_length = '0;
      req_bus.first        = 1'b0;
      req_bus.last         = 1'b0;

      // reset values of the engine
      model_wide = 1'b1;
      model_seed = SEED_RESET;
      model_acc  = '0;
      model_len  = '0;
      model_open = 1'b0;

      // --- directed table ---
      // reset config: one full word, 64-bit form, reset seed
      add_row(req_row(make_req('1, 4'd8, 32'd8, 1'b1, 1'b1), 1'b0, '0));
      // stray word with no message open: dropped
      add_row(req_row(make_req(64'h0123456789abcdef, 4'd8, 32'd8, 1'b0, 1'b1),
                      1'b0, '0));
      // zero seed, empty message: every step of either form yields zero
      add_row(csr_row(CSR_HASH_SEED, 32'd0));
      add_row(req_row(make_req('1, 4'd0, 32'd0, 1'b1, 1'b1), 1'b1, 64'd0));
      add_row(csr_row(CSR_WIDE_MODE, 32'd0));
      add_row(req_row(make_req('1, 4'd0, 32'd0, 1'b1, 1'b1), 1'b1, 64'd0));
      // 32-bit form, all-ones seed; short count on an inner word
      add_row(csr_row(CSR_HASH_SEED, 32'hffff_ffff));
      add_row(req_row(make_req('0, 4'd3, 32'hffff_ffff, 1'b1, 1'b0), 1'b0, '0));
      add_row(req_row(make_req('1, 4'd8, 32'd0, 1'b0, 1'b0), 1'b0, '0));
      add_row(req_row(make_req(64'hfedcba9876543210, 4'd5, 32'd0, 1'b0, 1'b1),
                      1'b0, '0));
      add_row(req_row(make_req('1, 4'd4, 32'd4, 1'b1, 1'b1), 1'b0, '0));
      add_row(req_row(make_req('1, 4'd3, 32'd3, 1'b1, 1'b1), 1'b0, '0));
      // open message cut off by a new first word; byte count above eight
      add_row(req_row(make_req(64'h5555aaaa5555aaaa, 4'd8, 32'd16, 1'b1, 1'b0),
                      1'b0, '0));
      add_row(req_row(make_req(64'haaaa5555aaaa5555, 4'd15, 32'd8, 1'b1, 1'b1),
                      1'b0, '0));
      // 64-bit form: tail lengths, oversize count, extreme length
      add_row(csr_row(CSR_WIDE_MODE, 32'hffff_ffff));
      add_row(req_row(make_req('0, 4'd8, 32'hffff_ffff, 1'b1, 1'b1), 1'b0, '0));
      add_row(req_row(make_req('1, 4'd8, 32'd15, 1'b1, 1'b0), 1'b0, '0));
      add_row(req_row(make_req('1, 4'd7, 32'd15, 1'b0, 1'b1), 1'b0, '0));
      add_row(req_row(make_req('1, 4'd1, 32'd1, 1'b1, 1'b1), 1'b0, '0));
      add_row(req_row(make_req('1, 4'd9, 32'd8, 1'b1, 1'b1), 1'b0, '0));
      // form switched mid-message, then seed written mid-message (not resampled)
      add_row(req_row(make_req(64'h0f0f0f0ff0f0f0f0, 4'd8, 32'd12, 1'b1, 1'b0),
                      1'b0, '0));
      add_row(csr_row(CSR_WIDE_MODE, 32'd0));
      add_row(req_row(make_req(64'h3c3c3c3cc3c3c3c3, 4'd4, 32'd12, 1'b0, 1'b1),
                      1'b0, '0));
      add_row(req_row(make_req(64'h9696969669696969, 4'd8, 32'd12, 1'b1, 1'b0),
                      1'b0, '0));
      add_row(csr_row(CSR_WIDE_MODE, 32'd1));
      add_row(csr_row(CSR_HASH_SEED, 32'h1234_5678));
      add_row(req_row(make_req(64'h8421842148124812, 4'd4, 32'd12, 1'b0, 1'b1),
                      1'b0, '0));

      repeat (7) @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) write_register(plan[i].csr_idx, plan[i].csr_val);
         else send_request(plan[i].req, plan[i].pinned, plan[i].pinned_hash);
      end

      // --- random phases: new settings each phase, extremes first ---
      phase       = 0;
      words_taken = 0;
      while (words_taken < WORD_TARGET) begin
         wide = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
         case (phase)
            0:       seed = 32'd0;
            1:       seed = 32'hffff_ffff;
            2:       seed = SEED_RESET;
            default: seed = $urandom;
         endcase
         // upper data bits of the mode write carry noise
         write_register(CSR_WIDE_MODE, ($urandom & 32'hffff_fffe) | {31'd0, wide});
         write_register(CSR_HASH_SEED, seed);
         // every fourth phase runs with both sides at full rate
         no_gaps    = (phase % 4 == 3);
         phase_base = words_taken;
         while (words_taken - phase_base < 170) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16)
                                                    : $urandom_range(1, 4);
               send_message(nwords, $urandom_range(0, 9) == 0);
            end else if (pick < 88) begin
               // word without first: dropped when idle, absorbed if one is open
               send_request(make_req(rand_word(), 4'($urandom), $urandom, 1'b0,
                                     1'($urandom_range(0, 1))));
            end else if (pick < 94) begin
               // message left open; the next first word abandons it
               nwords = $urandom_range(1, 3);
               for (int i = 0; i < nwords; i++)
                  send_request(make_req(rand_word(), 4'($urandom), $urandom, i == 0, 1'b0));
            end else begin
               send_request(make_req(rand_word(), 4'($urandom), $urandom,
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            end
         end
         phase++;
      end

      // drain, then give the engine time to show any stray hash
      req_bus.valid = 1'b0;
      no_gaps       = 1'b0;
      while (hashes_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
